@@ rtl/rca_pkg.sv @@
// Shared types and codes for the reference-counted ID allocator.
`timescale 1ns / 1ps

package rca_pkg;

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_INCR   = 3'd1,
    OP_DECR   = 3'd2,
    OP_QUERY  = 3'd3,
    OP_HAS    = 3'd4,
    OP_INIT   = 3'd5,
    OP_UNINIT = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NOT_INIT  = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_EXHAUSTED = 3'd3,
    STS_ALREADY   = 3'd4,
    STS_SATURATED = 3'd5
  } status_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] id_in;
  } req_t;

  typedef struct packed {
    logic [7:0]  id_out;
    logic [15:0] ref_count;
    logic        found;
    logic        released;
    logic [2:0]  status;
  } rsp_t;

endpackage

@@ rtl/rca_req_if.sv @@
// Request channel: valid/ready handshake carrying one operation beat.
`timescale 1ns / 1ps

interface rca_req_if ();
  logic          valid;
  logic          ready;
  rca_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/rca_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one result beat.
`timescale 1ns / 1ps

interface rca_rsp_if ();
  logic          valid;
  logic          ready;
  rca_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/rca_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/refcounted_id_allocator.sv @@
// A request beat is accepted in the idle state, where its count memory read is issued; the
//   execute state then computes the result, writes back and registers the response. A full,
//   unread response stalls write-back, and no new request is taken until the execute state completes.
// Reset: live and released bitmaps, next-fresh counter, ready flag and control clear at once.
// The count memory is not cleared; only entries written by allocate are ever used.
`timescale 1ns / 1ps

module refcounted_id_allocator #(
  parameter int NUM_IDS    = 256,
  parameter int COUNT_BITS = 16,
  parameter int INIT_COUNT = 1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rca_req_if.sink   req_i,
  rca_rsp_if.source rsp_o
);

  import rca_pkg::*;

  localparam int AW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int FW = AW + 1;
  localparam int CW = COUNT_BITS;
  localparam logic [CW-1:0] CNT_MAX = '1;
  // Starting count, clipped to the count width.
  localparam logic [CW-1:0] START =
    (longint'(INIT_COUNT) > ((longint'(1) << COUNT_BITS) - 1)) ? CNT_MAX : CW'(INIT_COUNT);

  // ---------------------------------------------------------------------------
  // Control and state registers
  // ---------------------------------------------------------------------------
  fsm_e state_q, state_d;

  logic [NUM_IDS-1:0] live_q, live_d;     // IDs currently handed out
  logic [NUM_IDS-1:0] rel_q, rel_d;       // IDs freed and available for reuse
  logic [FW-1:0]      fresh_q, fresh_d;   // next never-used ID
  logic               rdy_q, rdy_d;       // initialized flag

  // Latched request, captured on accept
  logic [2:0]    op_q;
  logic [7:0]    id_q;
  logic          in_rng_q;

  // Response output register
  logic          out_vld_q, out_vld_d;
  rsp_t          rsp_q, rsp_d;

  // Handshake and sequencing
  logic          in_fire;
  logic          out_fire;
  logic          done;       // execute cycle completes this cycle
  logic          commit;     // state and memory updates take effect

  // Count memory interface
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [CW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [CW-1:0] cnt;

  // Index decode of the request ID
  logic [AW-1:0] k;
  logic          known;

  // Smallest released ID
  logic [NUM_IDS-1:0] rel_low;
  logic [AW-1:0]      first_rel;

  // Per-operation results
  rsp_t          res;
  logic [CW-1:0] dec_cnt;

  assign in_fire  = req_i.valid && req_i.ready;
  assign out_fire = rsp_o.valid && rsp_o.ready;
  assign done     = (state_q == FSM_EXEC) && (!out_vld_q || rsp_o.ready);
  assign commit   = done;

  // Read address straight from the incoming beat; data lands for the execute cycle.
  // The single beat in flight means a write-back always retires before the next read,
  // so no forwarding path is needed.
  assign ram_raddr = AW'(req_i.data.id_in);

  rca_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_IDS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (ram_raddr),
    .rdata_o (cnt)
  );

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (in_fire) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (done) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    req_i.ready = 1'b0;
    case (state_q)
      FSM_IDLE: req_i.ready = 1'b1;
      FSM_EXEC: req_i.ready = 1'b0;
      default:  req_i.ready = 1'b0;
    endcase
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = rsp_q;

  // ---------------------------------------------------------------------------
  // Lookup: index, liveness, lowest released ID (isolate lowest set bit, then encode)
  // ---------------------------------------------------------------------------
  assign k       = AW'(id_q);
  assign known   = in_rng_q && live_q[k];
  assign rel_low = rel_q & (~rel_q + NUM_IDS'(1));

  always_comb begin
    first_rel = '0;
    for (int i = 0; i < NUM_IDS; i++) begin
      if (rel_low[i]) begin
        first_rel = first_rel | AW'(i);
      end
    end
  end

  assign dec_cnt = (cnt == '0) ? '0 : cnt - CW'(1);

  // ---------------------------------------------------------------------------
  // Execute: read-modify-write of the count entry and bitmap updates
  // ---------------------------------------------------------------------------
  always_comb begin
    res       = '{id_out: id_q, ref_count: '0, found: 1'b0, released: 1'b0,
                  status: STS_OK};
    live_d    = live_q;
    rel_d     = rel_q;
    fresh_d   = fresh_q;
    rdy_d     = rdy_q;
    ram_we    = 1'b0;
    ram_waddr = k;
    ram_wdata = cnt;

    case (op_q)
      OP_ALLOC: begin
        if (!rdy_q) begin
          res.status = STS_NOT_INIT;
        end else if (|rel_q) begin
          rel_d[first_rel]  = 1'b0;
          live_d[first_rel] = 1'b1;
          ram_we            = 1'b1;
          ram_waddr         = first_rel;
          ram_wdata         = START;
          res.id_out        = 8'(first_rel);
          res.ref_count     = 16'(START);
          res.found         = 1'b1;
        end else if (fresh_q < FW'(NUM_IDS)) begin
          fresh_d                  = fresh_q + FW'(1);
          live_d[fresh_q[AW-1:0]]  = 1'b1;
          ram_we                   = 1'b1;
          ram_waddr                = fresh_q[AW-1:0];
          ram_wdata                = START;
          res.id_out               = 8'(fresh_q[AW-1:0]);
          res.ref_count            = 16'(START);
          res.found                = 1'b1;
        end else begin
          res.status = STS_EXHAUSTED;
        end
      end
      OP_INCR: begin
        if (!rdy_q) begin
          res.status = STS_NOT_INIT;
        end else if (!known) begin
          res.status = STS_NOT_FOUND;
        end else if (cnt == CNT_MAX) begin
          res.ref_count = 16'(cnt);
          res.found     = 1'b1;
          res.status    = STS_SATURATED;
        end else begin
          ram_we        = 1'b1;
          ram_wdata     = cnt + CW'(1);
          res.ref_count = 16'(cnt + CW'(1));
          res.found     = 1'b1;
        end
      end
      OP_DECR: begin
        if (!rdy_q) begin
          res.status = STS_NOT_INIT;
        end else if (!known) begin
          res.status = STS_NOT_FOUND;
        end else begin
          ram_we        = 1'b1;
          ram_wdata     = dec_cnt;
          res.ref_count = 16'(dec_cnt);
          if (dec_cnt < START) begin
            live_d[k]    = 1'b0;
            rel_d[k]     = 1'b1;
            res.released = 1'b1;
          end else begin
            res.found = 1'b1;
          end
        end
      end
      OP_QUERY: begin
        if (!rdy_q) begin
          res.status = STS_NOT_INIT;
        end else if (!known) begin
          res.status = STS_NOT_FOUND;
        end else begin
          res.ref_count = 16'(cnt);
          res.found     = 1'b1;
        end
      end
      OP_HAS: begin
        if (!rdy_q) begin
          res.status = STS_NOT_INIT;
        end else begin
          res.found = known;
        end
      end
      OP_INIT: begin
        if (rdy_q) begin
          res.status = STS_ALREADY;
        end else begin
          live_d  = '0;
          rel_d   = '0;
          fresh_d = '0;
          rdy_d   = 1'b1;
        end
      end
      OP_UNINIT: begin
        if (!rdy_q) begin
          res.status = STS_NOT_INIT;
        end else begin
          live_d  = '0;
          rel_d   = '0;
          fresh_d = '0;
          rdy_d   = 1'b0;
        end
      end
      default: begin
        // unused code: echo only, no state change
      end
    endcase

    ram_we = ram_we && commit;
  end

  // Output register loads on completion, drains when the consumer takes the beat.
  always_comb begin
    out_vld_d = out_vld_q;
    rsp_d     = rsp_q;
    if (out_fire) begin
      out_vld_d = 1'b0;
    end
    if (done) begin
      out_vld_d = 1'b1;
      rsp_d     = res;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      live_q    <= '0;
      rel_q     <= '0;
      fresh_q   <= '0;
      rdy_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      if (commit) begin
        live_q  <= live_d;
        rel_q   <= rel_d;
        fresh_q <= fresh_d;
        rdy_q   <= rdy_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (in_fire) begin
      op_q     <= req_i.data.operation;
      id_q     <= req_i.data.id_in;
      in_rng_q <= (32'(req_i.data.id_in) < 32'(NUM_IDS));
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_live_rel_disjoint : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (live_q & rel_q) == '0)
    else $error("ID both live and released");

  a_fresh_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= FW'(NUM_IDS))
    else $error("next-fresh counter past ID range");

  a_idle_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rdy_q |-> (live_q == '0 && rel_q == '0 && fresh_q == '0))
    else $error("tables not empty while uninitialized");

  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == FSM_EXEC))
    else $error("accepted beat did not enter execute");

  a_rsp_from_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == FSM_EXEC))
    else $error("response produced without execute cycle");

endmodule

@@ tb/tb_refcounted_id_allocator.sv @@
// Self-checking testbench for the reference-counted ID allocator: random and directed beats.
`timescale 1ns / 1ps

module tb_refcounted_id_allocator;
  import rca_pkg::*;

  // Block configuration, matched by the scoreboard copy below.
  localparam int NUM_IDS    = 256;
  localparam int COUNT_BITS = 16;
  localparam int INIT_COUNT = 1;

  localparam int CLK_PERIOD = 4;

  // Opcode 7 is not in op_e; the block must answer it as a no-op.
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  // INIT_COUNT is clipped to the counter range.
  localparam logic [COUNT_BITS-1:0] START_COUNT =
    (INIT_COUNT > CNT_MAX) ? CNT_MAX : COUNT_BITS'(INIT_COUNT);

  localparam int RANDOM_OPS     = 500;
  localparam int CLIMB_STEPS    = 8;    // increments in the short count climb
  localparam int CALM_TAIL      = 150;  // last beats of the run go with no idling
  localparam int HOLD_AT        = 120;  // response count that triggers the long hold-off
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 1000; // cycles with no beat on either side
  localparam int TAIL_CYCLES    = 20;   // leave plenty of slack after the last beat
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    req_t beat;
    bit   drain;  // hold this beat until every owed response is back
  } queued_op_t;

  logic clk;
  logic rst_n;

  rca_req_if req_if ();
  rca_rsp_if rsp_if ();

  refcounted_id_allocator #(
    .NUM_IDS    (NUM_IDS),
    .COUNT_BITS (COUNT_BITS),
    .INIT_COUNT (INIT_COUNT)
  ) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scoreboard copy of the allocator state
  // ---------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] ref_counts [NUM_IDS];
  bit                    live_ids   [NUM_IDS];
  bit                    freed_ids  [NUM_IDS];
  int unsigned           fresh_next;
  bit                    armed;

  // What the run actually exercised, for the closing summary.
  int grants, exhausts, saturations, releases, misses, not_armed;

  queued_op_t op_backlog [$];    // beats still to be sent
  rsp_t       owed_responses [$]; // predicted responses, oldest first

  int reqs_seen;    // NBA-updated so other processes read pre-edge values
  int rsps_seen;
  int idle_cycles;
  int errors;
  bit calm;

  function automatic void wipe_tables();
    int i;
    for (i = 0; i < NUM_IDS; i++) begin
      ref_counts[i] = '0;
      live_ids[i]   = 1'b0;
      freed_ids[i]  = 1'b0;
    end
    fresh_next = 0;
  endfunction

  // Apply one request beat to the shadow state and return the response it owes.
  function automatic rsp_t resolve_op(req_t beat);
    rsp_t                  ans;
    logic [7:0]            id;
    bit                    known;
    int                    pick;
    int                    i;
    logic [COUNT_BITS-1:0] cnt;
    id    = beat.id_in;
    known = live_ids[id];
    ans   = '0;
    ans.id_out = id;
    ans.status = STS_OK;
    if (beat.operation == OP_UNUSED) return ans;
    // Init is the one opcode honored while disarmed.
    if (beat.operation == OP_INIT) begin
      if (armed) begin
        ans.status = STS_ALREADY;
      end else begin
        wipe_tables();
        armed = 1'b1;
      end
      return ans;
    end
    if (!armed) begin
      ans.status = STS_NOT_INIT;
      not_armed++;
      return ans;
    end
    case (beat.operation)
      OP_ALLOC: begin
        // Lowest released ID wins over a fresh one.
        pick = -1;
        for (i = NUM_IDS - 1; i >= 0; i--) begin
          if (freed_ids[i]) pick = i;
        end
        if (pick >= 0) begin
          freed_ids[pick] = 1'b0;
        end else if (fresh_next < NUM_IDS) begin
          pick = fresh_next;
          fresh_next++;
        end else begin
          ans.status = STS_EXHAUSTED;
          exhausts++;
          return ans;
        end
        live_ids[pick]   = 1'b1;
        ref_counts[pick] = START_COUNT;
        ans.id_out    = 8'(pick);
        ans.ref_count = 16'(START_COUNT);
        ans.found     = 1'b1;
        grants++;
      end
      OP_INCR: begin
        if (!known) begin
          ans.status = STS_NOT_FOUND;
          misses++;
        end else if (ref_counts[id] == CNT_MAX) begin
          // Saturated: count held, flagged.
          ans.status    = STS_SATURATED;
          ans.ref_count = 16'(ref_counts[id]);
          ans.found     = 1'b1;
          saturations++;
        end else begin
          ref_counts[id] = ref_counts[id] + 1'b1;
          ans.ref_count  = 16'(ref_counts[id]);
          ans.found      = 1'b1;
        end
      end
      OP_DECR: begin
        if (!known) begin
          ans.status = STS_NOT_FOUND;
          misses++;
        end else begin
          cnt = (ref_counts[id] == '0) ? '0 : ref_counts[id] - 1'b1;
          ref_counts[id] = cnt;
          ans.ref_count  = 16'(cnt);
          // Falling below the initial count frees the ID.
          if (cnt < START_COUNT) begin
            live_ids[id]  = 1'b0;
            freed_ids[id] = 1'b1;
            ans.released  = 1'b1;
            releases++;
          end else begin
            ans.found = 1'b1;
          end
        end
      end
      OP_QUERY: begin
        if (!known) begin
          ans.status = STS_NOT_FOUND;
          misses++;
        end else begin
          ans.ref_count = 16'(ref_counts[id]);
          ans.found     = 1'b1;
        end
      end
      OP_HAS: begin
        ans.found = known;
      end
      OP_UNINIT: begin
        wipe_tables();
        armed = 1'b0;
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;   // a stretch with no idling
      1:       return 10;
      default: return 30;
    endcase
  endfunction

  function automatic void queue_op(logic [2:0] op, logic [7:0] id, bit drain = 1'b0);
    queued_op_t item;
    item.beat.operation = op;
    item.beat.id_in     = id;
    item.drain          = drain;
    op_backlog.push_back(item);
  endfunction

  // Mostly well-formed traffic on a small ID window so that IDs stay live,
  // with a little noise: far-away IDs, init/uninit, the unused opcode.
  function automatic void queue_random_op();
    int         roll;
    logic [7:0] id;
    roll = $urandom_range(0, 99);
    id   = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 15))
                                        : 8'($urandom_range(0, 255));
    if (roll < 26)       queue_op(OP_ALLOC, 8'($urandom_range(0, 255)));
    else if (roll < 46)  queue_op(OP_INCR, id);
    else if (roll < 70)  queue_op(OP_DECR, id);
    else if (roll < 79)  queue_op(OP_QUERY, id);
    else if (roll < 88)  queue_op(OP_HAS, id);
    else if (roll < 93)  queue_op(OP_INIT, id);
    else if (roll < 95)  queue_op(OP_UNINIT, id);
    else                 queue_op(OP_UNUSED, id);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feeds the request channel from op_backlog
  // ---------------------------------------------------------------------------
  queued_op_t head;
  int         gap_left;
  int         gap_pct;
  int         sent;

  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (op_backlog.size() == 0) begin
          req_if.valid <= 1'b0;
        end else if (op_backlog[0].drain && (req_if.valid || reqs_seen != rsps_seen)) begin
          // Pause: nothing new until the block has answered everything.
          req_if.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < gap_pct) begin
          gap_left = $urandom_range(0, 9);
          req_if.valid <= 1'b0;
        end else begin
          head = op_backlog.pop_front();
          req_if.valid <= 1'b1;
          req_if.data  <= head.beat;
          sent++;
          if (sent % 40 == 0) gap_pct = pick_idle_pct();
        end
      end
      calm <= (op_backlog.size() <= CALM_TAIL);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on request beats, checks response beats, drives ready
  // ---------------------------------------------------------------------------
  rsp_t got;
  rsp_t want;
  int   stall_left;
  int   stall_pct;
  int   hold_left;
  bit   hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        owed_responses.push_back(resolve_op(req_if.data));
        reqs_seen <= reqs_seen + 1;
      end

      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        rsps_seen <= rsps_seen + 1;
        if ((rsps_seen + 1) % 40 == 0) stall_pct = pick_idle_pct();
        if (owed_responses.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("[%0t] unexpected response: id %0d count %0d found %0b rel %0b sts %0d",
                     $realtime, got.id_out, got.ref_count, got.found, got.released,
                     got.status);
        end else begin
          want = owed_responses.pop_front();
          if (got.id_out !== want.id_out || got.ref_count !== want.ref_count ||
              got.found !== want.found || got.released !== want.released ||
              got.status !== want.status) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("[%0t] response %0d mismatch:", $realtime, rsps_seen);
              $display("  expected id %0d count %0d found %0b rel %0b sts %0d",
                       want.id_out, want.ref_count, want.found, want.released,
                       want.status);
              $display("  actual   id %0d count %0d found %0b rel %0b sts %0d",
                       got.id_out, got.ref_count, got.found, got.released, got.status);
            end
          end
        end
      end

      idle_cycles <= ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                     ? 0 : idle_cycles + 1;

      // Ready: one long hold-off so the block backs up into its input,
      // otherwise random stall bursts, none in the calm tail.
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (!hold_done && rsps_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 9);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int  i;
    int  drain_at;
    bit  timed_out;

    clk          = 1'b0;
    rst_n        = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    reqs_seen    = 0;
    rsps_seen    = 0;
    idle_cycles  = 0;
    errors       = 0;
    calm         = 1'b0;
    gap_left     = 0;
    stall_left   = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    sent         = 0;
    gap_pct      = pick_idle_pct();
    stall_pct    = pick_idle_pct();
    armed        = 1'b0;
    grants = 0; exhausts = 0; saturations = 0; releases = 0; misses = 0; not_armed = 0;
    wipe_tables();
    timed_out    = 1'b0;

    // Directed: disarmed block, double init, basic life cycle of an ID,
    // unknown IDs, release and reuse, unused opcode, uninit.
    queue_op(OP_HAS, 8'd5);
    queue_op(OP_ALLOC, 8'h00);
    queue_op(OP_UNUSED, 8'hFF);
    queue_op(OP_UNINIT, 8'h55);
    queue_op(OP_INIT, 8'h00);
    queue_op(OP_INIT, 8'hFF);
    queue_op(OP_ALLOC, 8'hAA);
    queue_op(OP_ALLOC, 8'h55);
    queue_op(OP_INCR, 8'd0);
    queue_op(OP_QUERY, 8'd0);
    queue_op(OP_HAS, 8'd1);
    queue_op(OP_HAS, 8'd200);
    queue_op(OP_INCR, 8'd255);
    queue_op(OP_DECR, 8'd254);
    queue_op(OP_QUERY, 8'd128);
    queue_op(OP_DECR, 8'd0);
    queue_op(OP_DECR, 8'd0);
    queue_op(OP_DECR, 8'd0);
    queue_op(OP_ALLOC, 8'hFF);
    queue_op(OP_UNUSED, 8'h00);
    queue_op(OP_UNINIT, 8'h00);
    queue_op(OP_QUERY, 8'd0);
    queue_op(OP_INIT, 8'h00, 1'b1);

    // Exhaustion: hand out every ID, overflow, then reuse released ones low first.
    for (i = 0; i < NUM_IDS; i++) queue_op(OP_ALLOC, 8'($urandom_range(0, 255)));
    queue_op(OP_ALLOC, 8'($urandom_range(0, 255)));
    queue_op(OP_DECR, 8'd200);
    queue_op(OP_DECR, 8'd7);
    queue_op(OP_ALLOC, 8'h00);
    queue_op(OP_ALLOC, 8'h00);
    queue_op(OP_ALLOC, 8'hFF);
    queue_op(OP_INCR, 8'd255);
    queue_op(OP_QUERY, 8'd255);
    queue_op(OP_UNINIT, 8'h00);
    queue_op(OP_INIT, 8'h00);

    // Count climb: raise one ID a few steps, walk it back down and free it.
    queue_op(OP_ALLOC, 8'h00);
    for (i = 0; i < CLIMB_STEPS; i++) queue_op(OP_INCR, 8'd0);
    queue_op(OP_QUERY, 8'd0);
    for (i = 0; i < CLIMB_STEPS + 1; i++) queue_op(OP_DECR, 8'd0);
    queue_op(OP_QUERY, 8'd0);
    queue_op(OP_UNINIT, 8'h00);
    queue_op(OP_INIT, 8'h00);

    // Random traffic, with one more drain pause somewhere in the middle.
    drain_at = $urandom_range(RANDOM_OPS / 4, RANDOM_OPS / 2);
    for (i = 0; i < RANDOM_OPS; i++) begin
      if (i == drain_at) queue_op(OP_QUERY, 8'($urandom_range(0, 15)), 1'b1);
      else queue_random_op();
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Run until every beat is sent and answered, or the watchdog trips.
    while (op_backlog.size() != 0 || req_if.valid || reqs_seen != rsps_seen) begin
      @(posedge clk);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        timed_out = 1'b1;
        break;
      end
    end
    if (!timed_out) repeat (TAIL_CYCLES) @(posedge clk);

    if (owed_responses.size() != 0) begin
      errors += owed_responses.size();
      $display("%0d responses never arrived", owed_responses.size());
    end
    if (timed_out) $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);

    $display("Ran %0d operations (%0d answered, %0d bad): %0d grants, %0d releases,",
             reqs_seen, rsps_seen, errors, grants, releases);
    $display("  %0d exhausted, %0d saturated, %0d unknown-ID, %0d while disarmed",
             exhausts, saturations, misses, not_armed);

    if (!timed_out && errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/rca_pkg.sv
rtl/rca_req_if.sv
rtl/rca_rsp_if.sv
rtl/rca_ram.sv
rtl/refcounted_id_allocator.sv
tb/tb_refcounted_id_allocator.sv
